### rtl/core/cll_pkg.sv
// shared types and constants for the cursor linked list engine
package cll_pkg;

    localparam int CAPACITY   = 256;
    localparam int PTR_W      = 9;
    localparam int ADDR_W     = 8;
    localparam int DATA_WIDTH = 32;

    localparam logic [PTR_W-1:0] NIL = 9'd256;

    localparam logic [3:0] ACT_PREPEND    = 4'd0;
    localparam logic [3:0] ACT_APPEND     = 4'd1;
    localparam logic [3:0] ACT_INS_BEFORE = 4'd2;
    localparam logic [3:0] ACT_INS_AFTER  = 4'd3;
    localparam logic [3:0] ACT_DEL_FRONT  = 4'd4;
    localparam logic [3:0] ACT_DEL_BACK   = 4'd5;
    localparam logic [3:0] ACT_DEL_CURSOR = 4'd6;
    localparam logic [3:0] ACT_MV_FRONT   = 4'd7;
    localparam logic [3:0] ACT_MV_BACK    = 4'd8;
    localparam logic [3:0] ACT_MV_PREV    = 4'd9;
    localparam logic [3:0] ACT_MV_NEXT    = 4'd10;
    localparam logic [3:0] ACT_CLEAR      = 4'd11;
    localparam logic [3:0] ACT_RD_FRONT   = 4'd12;
    localparam logic [3:0] ACT_RD_BACK    = 4'd13;
    localparam logic [3:0] ACT_RD_CURSOR  = 4'd14;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_UNDEF = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // one memory port request
    typedef struct packed {
        logic              nxt_we;
        logic              prv_we;
        logic              val_we;
        logic [ADDR_W-1:0] addr;
        logic [PTR_W-1:0]  nxt_wd;
        logic [PTR_W-1:0]  prv_wd;
        logic [DATA_WIDTH-1:0] val_wd;
    } mem_req_t;

    typedef struct packed {
        logic [PTR_W-1:0]      nxt;
        logic [PTR_W-1:0]      prv;
        logic [DATA_WIDTH-1:0] val;
    } mem_rsp_t;

endpackage

### rtl/core/cll_node_mem.sv
// node memories: next links, prev links and values, one port each cycle
module cll_node_mem (
    input  logic              clk,
    input  cll_pkg::mem_req_t req,
    input  logic              init_we,
    input  logic [cll_pkg::ADDR_W-1:0] init_addr,
    output cll_pkg::mem_rsp_t rsp
);
    import cll_pkg::*;

    logic [PTR_W-1:0]      nxt_mem [CAPACITY];
    logic [PTR_W-1:0]      prv_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
    logic [PTR_W-1:0]      nxt_q_reg;
    logic [PTR_W-1:0]      prv_q_reg;
    logic [DATA_WIDTH-1:0] val_q_reg;

    always_ff @(posedge clk)
    begin
        if (init_we)
        begin
            nxt_mem[init_addr] <= {1'b0, init_addr} + PTR_W'(1);
        end
        else if (req.nxt_we)
        begin
            nxt_mem[req.addr] <= req.nxt_wd;
        end
        if (req.prv_we)
        begin
            prv_mem[req.addr] <= req.prv_wd;
        end
        if (req.val_we)
        begin
            val_mem[req.addr] <= req.val_wd;
        end
        nxt_q_reg <= nxt_mem[req.addr];
        prv_q_reg <= prv_mem[req.addr];
        val_q_reg <= val_mem[req.addr];
    end

    assign rsp = '{nxt: nxt_q_reg, prv: prv_q_reg, val: val_q_reg};
endmodule

### rtl/core/cursor_linked_list_engine_unit.sv
// top level of the cursor linked list engine
// Holds a doubly linked list of up to 256 signed 32-bit values in on-chip node
// memories with a free list. After reset a clearing pass writes the free chain;
// no transaction is accepted during it. Each action then runs on the single
// node memory port: accept in S_IDLE, reads and writes in S_A to S_D (read a
// neighbor link, then relink), and S_DONE loading the output register. Errors,
// clear, action 15 and moves to front or back go straight to S_DONE; reads and
// moves to the previous or next element use S_A; prepend and append use S_A,
// and S_B on a non-empty list; deletes use S_A, S_B, and S_C unless the tail goes;
// inserts use S_A to S_C, and S_D unless the new node is head or tail. A result
// is held until taken while the next action may be accepted; it waits in S_DONE.
module cursor_linked_list_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[3:0], value[35:4], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[1:0], read_value[33:2],
                                   // cursor_position[42:34], element_count[51:43], pad
);
    import cll_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A     = 4'd2;
    localparam logic [3:0] S_B     = 4'd3;
    localparam logic [3:0] S_C     = 4'd4;
    localparam logic [3:0] S_D     = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;

    logic [3:0]  state_reg, state_next;
    logic [8:0]  init_cnt_reg, init_cnt_next;
    logic [3:0]  act_reg, act_next;
    logic [31:0] val_reg, val_next;
    logic [PTR_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [PTR_W-1:0] cur_reg, cur_next, free_reg, free_next;
    logic [PTR_W-1:0] n_reg, n_next, t_reg, t_next;
    logic [8:0]  cidx_reg, cidx_next;
    logic [8:0]  len_reg, len_next;
    logic [1:0]  st_reg, st_next;
    logic [31:0] rd_reg, rd_next;
    logic        ovalid_reg, ovalid_next;
    logic [55:0] odata_reg, odata_next;
    mem_req_t    req;
    mem_rsp_t    rsp;
    logic        init_we;
    logic        empty, undef, full, acc;
    logic [3:0]  a;

    cll_node_mem u_mem (
        .clk       (clk),
        .req       (req),
        .init_we   (init_we),
        .init_addr (init_cnt_reg[ADDR_W-1:0]),
        .rsp       (rsp)
    );

    assign init_we  = (state_reg == S_INIT);
    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign a        = s_tdata[3:0];
    assign empty    = (len_reg == 9'd0);
    assign undef    = (cur_reg == NIL);
    assign full     = (free_reg == NIL);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb
    begin
        state_next = state_reg; init_cnt_next = init_cnt_reg;
        act_next = act_reg; val_next = val_reg;
        head_next = head_reg; tail_next = tail_reg; cur_next = cur_reg;
        free_next = free_reg; n_next = n_reg; t_next = t_reg;
        cidx_next = cidx_reg; len_next = len_reg; st_next = st_reg; rd_next = rd_reg;
        ovalid_next = ovalid_reg; odata_next = odata_reg;
        req = '0;
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_INIT:
            begin
                init_cnt_next = init_cnt_reg + 9'd1;
                if (init_cnt_reg == 9'd255)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    act_next = a;
                    val_next = s_tdata[35:4];
                    st_next  = ST_OK;
                    rd_next  = '0;
                    state_next = S_DONE;
                    if (a <= ACT_APPEND && full)
                        st_next = ST_FULL;
                    else if (a >= ACT_INS_BEFORE && a <= ACT_RD_CURSOR && a != ACT_CLEAR
                             && empty)
                        st_next = ST_EMPTY;
                    else if ((a == ACT_INS_BEFORE || a == ACT_INS_AFTER
                              || a == ACT_DEL_CURSOR || a == ACT_MV_PREV
                              || a == ACT_MV_NEXT || a == ACT_RD_CURSOR) && undef)
                        st_next = ST_UNDEF;
                    else if ((a == ACT_INS_BEFORE || a == ACT_INS_AFTER) && full)
                        st_next = ST_FULL;
                    else
                    begin
                        case (a)
                            ACT_PREPEND, ACT_APPEND, ACT_INS_BEFORE, ACT_INS_AFTER:
                            begin
                                // read free node link
                                req.addr = free_reg[ADDR_W-1:0];
                                n_next = free_reg;
                                state_next = S_A;
                            end
                            ACT_DEL_FRONT:
                            begin
                                req.addr = head_reg[ADDR_W-1:0];
                                n_next = head_reg;
                                state_next = S_A;
                            end
                            ACT_DEL_BACK:
                            begin
                                req.addr = tail_reg[ADDR_W-1:0];
                                n_next = tail_reg;
                                state_next = S_A;
                            end
                            ACT_DEL_CURSOR, ACT_MV_PREV, ACT_MV_NEXT, ACT_RD_CURSOR:
                            begin
                                req.addr = cur_reg[ADDR_W-1:0];
                                n_next = cur_reg;
                                state_next = S_A;
                            end
                            ACT_RD_FRONT:
                            begin
                                req.addr = head_reg[ADDR_W-1:0];
                                state_next = S_A;
                            end
                            ACT_RD_BACK:
                            begin
                                req.addr = tail_reg[ADDR_W-1:0];
                                state_next = S_A;
                            end
                            ACT_MV_FRONT:
                            begin
                                cur_next = head_reg; cidx_next = 9'd0;
                            end
                            ACT_MV_BACK:
                            begin
                                cur_next = tail_reg; cidx_next = len_reg - 9'd1;
                            end
                            ACT_CLEAR:
                            begin
                                if (!empty)
                                begin
                                    req.addr = tail_reg[ADDR_W-1:0];
                                    req.nxt_we = 1'b1;
                                    req.nxt_wd = free_reg;
                                    free_next = head_reg;
                                    head_next = NIL; tail_next = NIL;
                                    len_next = 9'd0;
                                    cur_next = NIL; cidx_next = 9'h1FF;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_A:
            begin
                state_next = S_DONE;
                case (act_reg)
                    ACT_PREPEND:
                    begin
                        free_next = rsp.nxt;
                        req.addr = n_reg[ADDR_W-1:0];
                        req.nxt_we = 1'b1; req.prv_we = 1'b1; req.val_we = 1'b1;
                        req.nxt_wd = head_reg; req.prv_wd = NIL; req.val_wd = val_reg;
                        if (head_reg == NIL)
                            tail_next = n_reg;
                        else
                            state_next = S_B;
                        t_next = head_reg;
                        head_next = n_reg;
                        len_next = len_reg + 9'd1;
                        if (!cidx_reg[8])
                            cidx_next = cidx_reg + 9'd1;
                    end
                    ACT_APPEND:
                    begin
                        free_next = rsp.nxt;
                        req.addr = n_reg[ADDR_W-1:0];
                        req.nxt_we = 1'b1; req.prv_we = 1'b1; req.val_we = 1'b1;
                        req.nxt_wd = NIL; req.prv_wd = tail_reg; req.val_wd = val_reg;
                        if (tail_reg == NIL)
                            head_next = n_reg;
                        else
                            state_next = S_B;
                        t_next = tail_reg;
                        tail_next = n_reg;
                        len_next = len_reg + 9'd1;
                    end
                    ACT_INS_BEFORE, ACT_INS_AFTER:
                    begin
                        // got free link, now read cursor links
                        free_next = rsp.nxt;
                        req.addr = cur_reg[ADDR_W-1:0];
                        state_next = S_B;
                    end
                    ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_CURSOR:
                    begin
                        // rsp holds links of node n
                        req.addr = n_reg[ADDR_W-1:0];
                        req.nxt_we = 1'b1; req.nxt_wd = free_reg;
                        free_next = n_reg;
                        len_next = len_reg - 9'd1;
                        if (act_reg == ACT_DEL_CURSOR || n_reg == cur_reg)
                        begin
                            cur_next = NIL; cidx_next = 9'h1FF;
                        end
                        else if (act_reg == ACT_DEL_FRONT && !cidx_reg[8])
                            cidx_next = cidx_reg - 9'd1;
                        t_next = rsp.nxt;
                        val_next = {23'd0, rsp.prv};
                        if (rsp.prv == NIL)
                            head_next = rsp.nxt;
                        if (rsp.nxt == NIL)
                            tail_next = rsp.prv;
                        state_next = S_B;
                    end
                    ACT_MV_PREV:
                    begin
                        cur_next = rsp.prv;
                        cidx_next = (rsp.prv == NIL) ? 9'h1FF : cidx_reg - 9'd1;
                    end
                    ACT_MV_NEXT:
                    begin
                        cur_next = rsp.nxt;
                        cidx_next = (rsp.nxt == NIL) ? 9'h1FF : cidx_reg + 9'd1;
                    end
                    ACT_RD_FRONT, ACT_RD_BACK, ACT_RD_CURSOR:
                    begin
                        rd_next = rsp.val;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_B:
            begin
                state_next = S_DONE;
                case (act_reg)
                    ACT_PREPEND:
                    begin
                        // old head points back to the new node
                        req.addr = t_reg[ADDR_W-1:0];
                        req.prv_we = 1'b1; req.prv_wd = n_reg;
                    end
                    ACT_APPEND:
                    begin
                        req.addr = t_reg[ADDR_W-1:0];
                        req.nxt_we = 1'b1; req.nxt_wd = n_reg;
                    end
                    ACT_INS_BEFORE:
                    begin
                        t_next = rsp.prv;
                        req.addr = n_reg[ADDR_W-1:0];
                        req.nxt_we = 1'b1; req.prv_we = 1'b1; req.val_we = 1'b1;
                        req.nxt_wd = cur_reg; req.prv_wd = rsp.prv; req.val_wd = val_reg;
                        if (rsp.prv == NIL)
                            head_next = n_reg;
                        len_next = len_reg + 9'd1;
                        cidx_next = cidx_reg + 9'd1;
                        state_next = S_C;
                    end
                    ACT_INS_AFTER:
                    begin
                        t_next = rsp.nxt;
                        req.addr = n_reg[ADDR_W-1:0];
                        req.nxt_we = 1'b1; req.prv_we = 1'b1; req.val_we = 1'b1;
                        req.nxt_wd = rsp.nxt; req.prv_wd = cur_reg; req.val_wd = val_reg;
                        if (rsp.nxt == NIL)
                            tail_next = n_reg;
                        len_next = len_reg + 9'd1;
                        state_next = S_C;
                    end
                    ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_CURSOR:
                    begin
                        // prev.next = q
                        if (val_reg[PTR_W-1:0] != NIL)
                        begin
                            req.addr = val_reg[ADDR_W-1:0];
                            req.nxt_we = 1'b1; req.nxt_wd = t_reg;
                        end
                        if (t_reg != NIL)
                            state_next = S_C;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_C:
            begin
                state_next = S_DONE;
                case (act_reg)
                    ACT_INS_BEFORE:
                    begin
                        req.addr = cur_reg[ADDR_W-1:0];
                        req.prv_we = 1'b1; req.prv_wd = n_reg;
                        if (t_reg != NIL)
                            state_next = S_D;
                    end
                    ACT_INS_AFTER:
                    begin
                        req.addr = cur_reg[ADDR_W-1:0];
                        req.nxt_we = 1'b1; req.nxt_wd = n_reg;
                        if (t_reg != NIL)
                            state_next = S_D;
                    end
                    ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_CURSOR:
                    begin
                        req.addr = t_reg[ADDR_W-1:0];
                        req.prv_we = 1'b1; req.prv_wd = val_reg[PTR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_D:
            begin
                state_next = S_DONE;
                case (act_reg)
                    ACT_INS_BEFORE:
                    begin
                        req.addr = t_reg[ADDR_W-1:0];
                        req.nxt_we = 1'b1; req.nxt_wd = n_reg;
                    end
                    ACT_INS_AFTER:
                    begin
                        req.addr = t_reg[ADDR_W-1:0];
                        req.prv_we = 1'b1; req.prv_wd = n_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next = {4'd0, len_reg, cidx_reg, rd_reg, st_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT; init_cnt_reg <= '0;
            head_reg <= NIL; tail_reg <= NIL; cur_reg <= NIL; free_reg <= '0;
            cidx_reg <= 9'h1FF; len_reg <= '0; ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; init_cnt_reg <= init_cnt_next;
            head_reg <= head_next; tail_reg <= tail_next; cur_reg <= cur_next;
            free_reg <= free_next; cidx_reg <= cidx_next; len_reg <= len_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next; val_reg <= val_next; n_reg <= n_next; t_reg <= t_next;
        st_reg <= st_next; rd_reg <= rd_next; odata_reg <= odata_next;
    end
endmodule

### verif/tb_top.sv
// self-checking testbench for the cursor linked list engine
module tb_top;
    import cll_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [8:0]  cursor_position;
        logic [8:0]  element_count;
    } list_result_t;

    class list_scoreboard;
        logic [31:0] vals [CAPACITY];
        logic [8:0]  nxt [CAPACITY];
        logic [8:0]  prv [CAPACITY];
        logic [8:0]  head, tail, cur, free_head, length;
        int          cur_idx;
        list_result_t pending [$];
        int          errors;

        function new();
            for (int i = 0; i < CAPACITY; i++)
            begin
                vals[i] = '0;
                prv[i] = '0;
                nxt[i] = 9'(i + 1);
            end
            head = NIL;
            tail = NIL;
            cur = NIL;
            free_head = '0;
            length = '0;
            cur_idx = -1;
            errors = 0;
        endfunction

        function logic [8:0] get_nxt(logic [8:0] p);
            return (p < NIL) ? nxt[p[7:0]] : NIL;
        endfunction

        function logic [8:0] get_prv(logic [8:0] p);
            return (p < NIL) ? prv[p[7:0]] : NIL;
        endfunction

        function void set_nxt(logic [8:0] p, logic [8:0] v);
            if (p < NIL)
                nxt[p[7:0]] = v;
        endfunction

        function void set_prv(logic [8:0] p, logic [8:0] v);
            if (p < NIL)
                prv[p[7:0]] = v;
        endfunction

        function logic [8:0] take_node(logic [31:0] v);
            logic [8:0] n;
            n = free_head;
            free_head = get_nxt(n);
            if (n < NIL)
                vals[n[7:0]] = v;
            return n;
        endfunction

        function void unlink_node(logic [8:0] n);
            logic [8:0] p, q;
            p = get_prv(n);
            q = get_nxt(n);
            if (p == NIL) head = q; else set_nxt(p, q);
            if (q == NIL) tail = p; else set_prv(q, p);
            set_nxt(n, free_head);
            free_head = n;
            length = length - 9'd1;
        endfunction

        function logic [31:0] read_node(logic [8:0] n);
            return (n < NIL) ? vals[n[7:0]] : '0;
        endfunction

        function bit is_full();
            return free_head == NIL;
        endfunction

        function void note_action(logic [3:0] act, logic [31:0] value);
            list_result_t r;
            logic [8:0] n, c, p, q;
            bit empty, undef, full, cur_act;
            empty = (length == 0);
            undef = (cur == NIL);
            full = (free_head == NIL);
            cur_act = act inside {ACT_INS_BEFORE, ACT_INS_AFTER, ACT_DEL_CURSOR,
                                  ACT_MV_PREV, ACT_MV_NEXT, ACT_RD_CURSOR};
            r.status = ST_OK;
            r.read_value = '0;
            c = cur;
            if (act <= ACT_APPEND && full)
                r.status = ST_FULL;
            else if (act >= ACT_INS_BEFORE && act <= ACT_RD_CURSOR && act != ACT_CLEAR
                     && empty)
                r.status = ST_EMPTY;
            else if (cur_act && undef)
                r.status = ST_UNDEF;
            else if ((act == ACT_INS_BEFORE || act == ACT_INS_AFTER) && full)
                r.status = ST_FULL;
            else
            begin
                case (act)
                    ACT_PREPEND:
                    begin
                        n = take_node(value);
                        set_prv(n, NIL);
                        set_nxt(n, head);
                        if (head == NIL) tail = n; else set_prv(head, n);
                        head = n;
                        length = length + 9'd1;
                        if (cur_idx >= 0) cur_idx++;
                    end
                    ACT_APPEND:
                    begin
                        n = take_node(value);
                        set_nxt(n, NIL);
                        set_prv(n, tail);
                        if (tail == NIL) head = n; else set_nxt(tail, n);
                        tail = n;
                        length = length + 9'd1;
                    end
                    ACT_INS_BEFORE:
                    begin
                        p = get_prv(c);
                        n = take_node(value);
                        set_prv(n, p);
                        set_nxt(n, c);
                        set_prv(c, n);
                        if (p == NIL) head = n; else set_nxt(p, n);
                        length = length + 9'd1;
                        cur_idx++;
                    end
                    ACT_INS_AFTER:
                    begin
                        q = get_nxt(c);
                        n = take_node(value);
                        set_nxt(n, q);
                        set_prv(n, c);
                        set_nxt(c, n);
                        if (q == NIL) tail = n; else set_prv(q, n);
                        length = length + 9'd1;
                    end
                    ACT_DEL_FRONT:
                    begin
                        n = head;
                        if (n == c)
                        begin
                            cur = NIL;
                            cur_idx = -1;
                        end
                        else if (cur_idx >= 0)
                            cur_idx--;
                        unlink_node(n);
                    end
                    ACT_DEL_BACK:
                    begin
                        n = tail;
                        if (n == c)
                        begin
                            cur = NIL;
                            cur_idx = -1;
                        end
                        unlink_node(n);
                    end
                    ACT_DEL_CURSOR:
                    begin
                        unlink_node(c);
                        cur = NIL;
                        cur_idx = -1;
                    end
                    ACT_MV_FRONT:
                    begin
                        cur = head;
                        cur_idx = 0;
                    end
                    ACT_MV_BACK:
                    begin
                        cur = tail;
                        cur_idx = int'(length) - 1;
                    end
                    ACT_MV_PREV:
                    begin
                        cur = get_prv(c);
                        if (cur == NIL) cur_idx = -1; else cur_idx--;
                    end
                    ACT_MV_NEXT:
                    begin
                        cur = get_nxt(c);
                        if (cur == NIL) cur_idx = -1; else cur_idx++;
                    end
                    ACT_CLEAR:
                    begin
                        if (!empty)
                        begin
                            set_nxt(tail, free_head);
                            free_head = head;
                            head = NIL;
                            tail = NIL;
                            length = '0;
                            cur = NIL;
                            cur_idx = -1;
                        end
                    end
                    ACT_RD_FRONT: r.read_value = read_node(head);
                    ACT_RD_BACK: r.read_value = read_node(tail);
                    ACT_RD_CURSOR: r.read_value = read_node(c);
                    default: ;
                endcase
            end
            r.cursor_position = 9'(cur_idx);
            r.element_count = length;
            pending.push_back(r);
        endfunction

        task automatic report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task automatic check_result(logic [55:0] d);
            list_result_t e;
            if (pending.size() == 0)
            begin
                report("unexpected transaction", d[31:0], '0);
                return;
            end
            e = pending.pop_front();
            if (d[1:0] !== e.status)
                report("status", 32'(d[1:0]), 32'(e.status));
            if (d[33:2] !== e.read_value) report("read_value", d[33:2], e.read_value);
            if (d[42:34] !== e.cursor_position)
                report("cursor_position", 32'(d[42:34]), 32'(e.cursor_position));
            if (d[51:43] !== e.element_count)
                report("element_count", 32'(d[51:43]), 32'(e.element_count));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // action[3:0], value[35:4], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // status[1:0], read_value[33:2], cursor_position[42:34],
                            // element_count[51:43], pad

    list_scoreboard sb;
    bit   sending_done;
    bit   hold_off;
    int   idle_cycles = 0;

    cursor_linked_list_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic send_action(logic [3:0] act, logic [31:0] value);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, value, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_action(act, value);
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'hffffffff;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // mostly builds and walks the list, with bursts that fill it to capacity
    function automatic logic [3:0] rand_action(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (phase == 1)
            return (r < 85) ? ((r & 1) ? ACT_APPEND : ACT_PREPEND) : 4'($urandom_range(0, 15));
        if (r < 30) return 4'($urandom_range(0, 3));
        if (r < 42) return 4'($urandom_range(4, 6));
        if (r < 75) return 4'($urandom_range(7, 10));
        if (r < 77) return ACT_CLEAR;
        if (r < 97) return 4'($urandom_range(12, 14));
        return 4'd15;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0) || sending_done;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int phase;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sending_done = 1'b0;
        hold_off = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases, extremes, each action
        for (int a = 2; a <= 15; a++)
            send_action(4'(a), '0);
        send_action(ACT_PREPEND, 32'h7fffffff);
        send_action(ACT_APPEND, 32'h80000000);
        send_action(ACT_INS_BEFORE, 32'h1);
        send_action(ACT_RD_CURSOR, '0);
        send_action(ACT_MV_FRONT, '0);
        send_action(ACT_MV_PREV, '0);
        send_action(ACT_MV_BACK, '0);
        send_action(ACT_MV_NEXT, '0);
        send_action(ACT_MV_BACK, '0);
        send_action(ACT_INS_AFTER, 32'hffffffff);
        send_action(ACT_DEL_BACK, '0);
        send_action(ACT_MV_FRONT, '0);
        send_action(ACT_DEL_FRONT, '0);
        send_action(ACT_CLEAR, '0);

        fork
            begin
                repeat (300) @(posedge clk);
                hold_off <= 1'b1;
                repeat (200) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none

        for (int i = 0; i < 1450; i++)
        begin
            phase = ((i / 300) % 2 == 1) && ((i % 300) < 280) ? 1 : 0;
            send_action(rand_action(phase), rand_value());
            if ($urandom_range(0, 7) == 0)
                pause_sender();
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
rtl/core/cll_pkg.sv
rtl/core/cll_node_mem.sv
rtl/core/cursor_linked_list_engine_unit.sv
verif/tb_top.sv
